FILE: hw/rtl/pid_velocity_controller_macros.svh
// ----------------------------------------------------------------------------
// PID velocity controller assertion macros
// Assertion macros used by the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef PID_VELOCITY_CONTROLLER_MACROS_SVH
`define PID_VELOCITY_CONTROLLER_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define PVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define PVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define PVC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// PID velocity controller package
// Shared constants, register codes, state codes and structures.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

    localparam int SOLVE_PERIOD = 0;

    localparam logic [22:0]        DT_MAX        = 23'd6553500;
    localparam logic [13:0]        TICKS_PER_SEC = 14'd10000;
    localparam logic signed [25:0] SOLVE_TICKS   = 26'(SOLVE_PERIOD * 100);

    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 16;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 34;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [15:0] FILT_KEEP = 16'd64553;
    localparam logic [9:0]  FILT_NEW  = 10'd983;
    localparam logic [15:0] HUND_DIV  = 16'd100;
    localparam logic [15:0] DTQ_DIV   = 16'd10000;
    localparam logic [15:0] KI_DIV    = 16'd1000;
    localparam logic [15:0] PCT_DIV   = 16'd100;

    localparam int MODE_NEG_ERR = 0;
    localparam int MODE_NEG_OUT = 1;

    typedef enum logic [2:0] {
        REG_KP, REG_KI, REG_KD, REG_BIAS, REG_UPPER, REG_LOWER, REG_SLEW, REG_MODE
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TIME, ST_FILT, ST_HUND, ST_DTQ, ST_KI, ST_IMUL, ST_IDIV,
        ST_PMUL, ST_PDIV, ST_D100, ST_DMUL, ST_DDIV, ST_SLEW, ST_FINAL, ST_OUT
    } t_state;

    typedef struct packed {
        logic [15:0]        kp;
        logic [15:0]        ki;
        logic [15:0]        kd;
        logic signed [15:0] bias;
        logic signed [15:0] upper;
        logic signed [15:0] lower;
        logic [15:0]        slew;
        logic [1:0]         mode;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] control_value;
        logic [15:0]        elapsed_hundredths;
        logic               solved;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/pvc_mul.sv
// ----------------------------------------------------------------------------
// PID velocity controller serial multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_mul import pvc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic                    o_done,
    output logic [MUL_A_W-1:0]      o_prod
);

    logic                 r_busy;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_A_W-1:0]   r_acc;

    assign o_done = r_busy && (r_cnt == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= MUL_CNT_W'(MUL_B_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[MUL_A_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pvc_div.sv
// ----------------------------------------------------------------------------
// PID velocity controller serial divider
// Restoring divider, one quotient bit per cycle, optional half-up rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_div import pvc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [DIV_N_W-1:0] i_num,
    input  wire logic [DIV_D_W-1:0] i_den,
    input  wire logic               i_rnd,
    output logic                    o_done,
    output logic [DIV_N_W-1:0]      o_quo
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_num;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W:0]     w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_num[DIV_N_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_N_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num + (i_rnd ? DIV_N_W'(i_den >> 1) : '0);
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= w_ge ? DIV_D_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
            r_num <= {r_num[DIV_N_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pvc_core.sv
// ----------------------------------------------------------------------------
// PID velocity controller solver core
// Sequencer that runs one solve through the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_core import pvc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_setpoint,
    input  wire logic signed [15:0] i_process_value,
    input  wire logic [31:0]        i_now_seconds,
    input  wire logic [13:0]        i_now_ticks,
    output logic                    o_idle,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output t_result                 o_res
);

    t_state r_state, n_state;
    logic   r_wait, n_wait;

    logic signed [15:0] r_sp, r_pv;
    logic [31:0]        r_now_s;
    logic [13:0]        r_now_t;

    logic [31:0]        r_last_s;
    logic [13:0]        r_last_t;
    logic signed [15:0] r_last_pv, r_last_err, r_last_ctl, r_held;
    logic signed [31:0] r_last_filt;

    logic               r_first, r_solve;
    logic [22:0]        r_dt;
    logic [15:0]        r_hund;
    logic [25:0]        r_dtq;
    logic signed [15:0] r_err, r_gerr, r_ctl;
    logic signed [31:0] r_filt;
    logic [63:0]        r_prod;
    logic [33:0]        r_den;
    logic signed [63:0] r_delta;
    t_result            r_res;

    logic               mul_go, mul_done, div_go, div_done, div_rnd;
    logic [63:0]        mul_a, mul_prod, div_num, div_quo;
    logic [15:0]        mul_b;
    logic [33:0]        div_den;
    logic               use_mul, use_div, unit_done;
    t_state             next_op;

    pvc_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(mul_go), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_prod(mul_prod)
    );

    pvc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_num(div_num),
        .i_den(div_den), .i_rnd(div_rnd), .o_done(div_done), .o_quo(div_quo)
    );

    logic [31:0]        w_dsec;
    logic               w_big;
    logic [23:0]        w_sec_ticks;
    logic signed [25:0] w_raw;
    logic [22:0]        w_dt;
    logic               w_solve;
    logic signed [15:0] w_err0, w_err;
    logic [15:0]        w_err_abs, w_gerr_abs, w_diff_abs;
    logic [31:0]        w_filt_abs;
    logic signed [16:0] w_diff;
    logic [15:0]        w_ki;

    assign w_dsec      = r_now_s - r_last_s;
    assign w_big       = |w_dsec[31:10];
    assign w_sec_ticks = w_dsec[9:0] * TICKS_PER_SEC;
    assign w_raw       = $signed({2'b00, w_sec_ticks}) + $signed({12'b0, r_now_t})
                         - $signed({12'b0, r_last_t});
    assign w_err0      = r_sp - r_pv;
    assign w_err       = i_cfg.mode[MODE_NEG_ERR] ? -w_err0 : w_err0;
    assign w_err_abs   = r_err[15] ? 16'(-r_err) : 16'(r_err);
    assign w_gerr_abs  = r_gerr[15] ? 16'(-r_gerr) : 16'(r_gerr);
    assign w_filt_abs  = r_filt[31] ? 32'(-r_filt) : 32'(r_filt);
    assign w_diff      = {i_cfg.upper[15], i_cfg.upper} - {i_cfg.lower[15], i_cfg.lower};
    assign w_diff_abs  = w_diff[16] ? 16'(-w_diff) : 16'(w_diff);
    assign w_ki        = (i_cfg.ki == '0) ? 16'd1 : i_cfg.ki;

    always_comb begin
        if (r_last_s == '0) begin
            w_dt    = '0;
            w_solve = 1'b1;
        end else begin
            if (w_big) begin
                w_dt = DT_MAX;
            end else if (w_raw < 0) begin
                w_dt = '0;
            end else if (w_raw > $signed({3'b000, DT_MAX})) begin
                w_dt = DT_MAX;
            end else begin
                w_dt = w_raw[22:0];
            end
            w_solve = (SOLVE_PERIOD == 0) || w_big || (w_raw > SOLVE_TICKS);
        end
    end

    // Derivative filter update, saturated to 32 bits.
    logic signed [31:0] w_old;
    logic signed [48:0] w_keep, w_keep_abs;
    logic [32:0]        w_keep_rnd;
    logic signed [33:0] w_keep_s;
    logic signed [16:0] w_dpv;
    logic signed [27:0] w_new;
    logic signed [34:0] w_sum;
    logic signed [31:0] w_filt;

    assign w_old      = r_first ? 32'sd0 : r_last_filt;
    assign w_keep     = w_old * $signed({1'b0, FILT_KEEP});
    assign w_keep_abs = w_keep[48] ? -w_keep : w_keep;
    assign w_keep_rnd = 33'((w_keep_abs + 49'sd32768) >>> 16);
    assign w_keep_s   = w_keep[48] ? -$signed({1'b0, w_keep_rnd}) : $signed({1'b0, w_keep_rnd});
    assign w_dpv      = (r_last_pv != '0) ? ({r_pv[15], r_pv} - {r_last_pv[15], r_last_pv})
                                          : 17'sd0;
    assign w_new      = w_dpv * $signed({1'b0, FILT_NEW});
    assign w_sum      = 35'(w_new) + 35'(w_keep_s);

    always_comb begin
        if (w_sum > 35'sh7FFFFFFF) begin
            w_filt = 32'sh7FFFFFFF;
        end else if (w_sum < -35'sh80000000) begin
            w_filt = 32'sh80000000;
        end else begin
            w_filt = w_sum[31:0];
        end
    end

    // Final sum, clamp and truncation toward zero.
    logic signed [63:0] w_v, w_up, w_lo, w_negv;
    logic signed [15:0] w_cv, w_out;

    assign w_v    = r_delta + {{32{r_ctl[15]}}, r_ctl, 16'b0};
    assign w_up   = {{32{i_cfg.upper[15]}}, i_cfg.upper, 16'b0};
    assign w_lo   = {{32{i_cfg.lower[15]}}, i_cfg.lower, 16'b0};
    assign w_negv = -w_v;

    always_comb begin
        if (w_v > w_up) begin
            w_cv = i_cfg.upper;
        end else if (w_v < w_lo) begin
            w_cv = i_cfg.lower;
        end else if (!w_v[63]) begin
            w_cv = w_v[31:16];
        end else begin
            w_cv = -$signed(w_negv[31:16]);
        end
        w_out = i_cfg.mode[MODE_NEG_OUT] ? -w_cv : w_cv;
    end

    // Slew rate from the divider quotient.
    logic signed [63:0] w_q_s, w_rate;

    assign w_q_s  = $signed(div_quo);
    assign w_rate = w_diff[16] ? -w_q_s : w_q_s;

    assign o_idle      = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_OUT);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        mul_go  = 1'b0;
        div_go  = 1'b0;
        use_mul = 1'b0;
        use_div = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        div_rnd = 1'b1;
        next_op = ST_OUT;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_TIME;
                end
            end
            ST_TIME:  n_state = ST_FILT;
            ST_FILT:  n_state = ST_HUND;
            ST_HUND: begin
                use_div = 1'b1;
                div_num = 64'(r_dt);
                div_den = 34'(HUND_DIV);
                div_rnd = 1'b0;
                next_op = r_solve ? ST_DTQ : ST_OUT;
            end
            ST_DTQ: begin
                use_div = 1'b1;
                div_num = {25'b0, r_dt, 16'b0};
                div_den = 34'(DTQ_DIV);
                next_op = ST_KI;
            end
            ST_KI: begin
                use_mul = 1'b1;
                mul_a   = 64'(r_dtq);
                mul_b   = w_ki;
                next_op = ST_IMUL;
            end
            ST_IMUL: begin
                use_mul = 1'b1;
                mul_a   = r_prod;
                mul_b   = w_err_abs;
                next_op = ST_IDIV;
            end
            ST_IDIV: begin
                use_div = 1'b1;
                div_num = r_prod;
                div_den = 34'(KI_DIV);
                next_op = ST_PMUL;
            end
            ST_PMUL: begin
                use_mul = 1'b1;
                mul_a   = 64'(w_gerr_abs);
                mul_b   = i_cfg.kp;
                next_op = ST_PDIV;
            end
            ST_PDIV: begin
                use_div = 1'b1;
                div_num = {r_prod[47:0], 16'b0};
                div_den = 34'(PCT_DIV);
                if (r_dt != '0) begin
                    next_op = ST_D100;
                end else begin
                    next_op = (i_cfg.slew != '0) ? ST_SLEW : ST_FINAL;
                end
            end
            ST_D100: begin
                use_mul = 1'b1;
                mul_a   = 64'(r_dtq);
                mul_b   = PCT_DIV;
                next_op = ST_DMUL;
            end
            ST_DMUL: begin
                use_mul = 1'b1;
                mul_a   = 64'(w_filt_abs);
                mul_b   = i_cfg.kd;
                next_op = ST_DDIV;
            end
            ST_DDIV: begin
                use_div = 1'b1;
                div_num = {r_prod[47:0], 16'b0};
                div_den = r_den;
                next_op = (i_cfg.slew != '0) ? ST_SLEW : ST_FINAL;
            end
            ST_SLEW: begin
                use_div = 1'b1;
                div_num = {32'b0, w_diff_abs, 16'b0};
                div_den = 34'(i_cfg.slew);
                next_op = ST_FINAL;
            end
            ST_FINAL: n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        unit_done = use_mul ? mul_done : div_done;
        if (use_mul || use_div) begin
            if (!r_wait) begin
                mul_go = use_mul;
                div_go = use_div;
                n_wait = 1'b1;
            end else if (unit_done) begin
                n_wait  = 1'b0;
                n_state = next_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_s    <= '0;
            r_last_t    <= '0;
            r_last_pv   <= '0;
            r_last_err  <= '0;
            r_last_ctl  <= '0;
            r_held      <= '0;
            r_last_filt <= '0;
        end else if (r_state == ST_FINAL) begin
            r_last_s    <= r_now_s;
            r_last_t    <= r_now_t;
            r_last_pv   <= r_pv;
            r_last_err  <= r_err;
            r_last_filt <= r_filt;
            r_last_ctl  <= w_cv;
            r_held      <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_sp    <= i_setpoint;
            r_pv    <= i_process_value;
            r_now_s <= i_now_seconds;
            r_now_t <= i_now_ticks;
        end
        if (r_state == ST_TIME) begin
            r_first <= (r_last_s == '0);
            r_dt    <= w_dt;
            r_solve <= w_solve;
            r_ctl   <= (r_last_s == '0) ? i_cfg.bias : r_last_ctl;
            r_err   <= w_err;
            r_gerr  <= w_err - r_last_err;
        end
        if (r_state == ST_FILT) begin
            r_filt <= w_filt;
        end
        if (r_wait && unit_done) begin
            unique case (r_state)
                ST_HUND: begin
                    r_hund <= div_quo[15:0];
                    r_res  <= '{control_value: r_held,
                                elapsed_hundredths: div_quo[15:0], solved: 1'b0};
                end
                ST_DTQ:  r_dtq <= div_quo[25:0];
                ST_KI, ST_IMUL, ST_PMUL, ST_DMUL: r_prod <= mul_prod;
                ST_D100: r_den <= mul_prod[33:0];
                ST_IDIV: r_delta <= r_err[15] ? -w_q_s : w_q_s;
                ST_PDIV: r_delta <= r_gerr[15] ? r_delta - w_q_s : r_delta + w_q_s;
                ST_DDIV: r_delta <= r_filt[31] ? r_delta + w_q_s : r_delta - w_q_s;
                ST_SLEW: begin
                    if (r_delta < 0) begin
                        if (-r_delta > w_rate) begin
                            r_delta <= -w_rate;
                        end
                    end else if (r_delta > w_rate) begin
                        r_delta <= w_rate;
                    end
                end
                default: r_prod <= r_prod;
            endcase
        end
        if (r_state == ST_FINAL) begin
            r_res <= '{control_value: w_out, elapsed_hundredths: r_hund, solved: 1'b1};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pid_velocity_controller.sv
// ----------------------------------------------------------------------------
// PID velocity controller
// Velocity-form PID solver in Q16.16 fixed point with stream ports.
// ----------------------------------------------------------------------------
// Each input word carries setpoint, process value and the current time. The
// block returns one output word per input word: the new or held control value,
// the elapsed time in hundredths of a second and a solved flag on tuser.
// Gains, bias, limits, slew and mode are written over the APB port; the user
// must write them only while idle, which the block itself does not enforce.
// One item is in work at a time. A full solve runs the 64-step serial divider
// four to six times and the 16-step serial multiplier three to five times; a
// held result runs the divider once. The result sits in an output register, so
// the next word is taken while it waits for the receiver; a stalled receiver
// holds the word until tready. Reset clears all controller history, so the
// next solve loads the bias value.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_velocity_controller import pvc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // setpoint[15:0], process_value[31:16], now_seconds[63:32], now_ticks[77:64]
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // control_value[15:0], elapsed_hundredths[31:16]
    output logic [31:0]      m_axis_tdata,
    // solved[0]
    output logic [0:0]       m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     core_idle, res_valid, res_ready, r_m_valid;
    t_result  core_res, r_m_res;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{kp: '0, ki: '0, kd: '0, bias: '0, upper: 16'sh7FFF,
                       lower: 16'sh8000, slew: '0, mode: '0};
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_KP:    r_cfg.kp    <= pwdata[15:0];
                REG_KI:    r_cfg.ki    <= pwdata[15:0];
                REG_KD:    r_cfg.kd    <= pwdata[15:0];
                REG_BIAS:  r_cfg.bias  <= pwdata[15:0];
                REG_UPPER: r_cfg.upper <= pwdata[15:0];
                REG_LOWER: r_cfg.lower <= pwdata[15:0];
                REG_SLEW:  r_cfg.slew  <= pwdata[15:0];
                REG_MODE:  r_cfg.mode  <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_KP:    prdata = {16'b0, r_cfg.kp};
            REG_KI:    prdata = {16'b0, r_cfg.ki};
            REG_KD:    prdata = {16'b0, r_cfg.kd};
            REG_BIAS:  prdata = {16'b0, r_cfg.bias};
            REG_UPPER: prdata = {16'b0, r_cfg.upper};
            REG_LOWER: prdata = {16'b0, r_cfg.lower};
            REG_SLEW:  prdata = {16'b0, r_cfg.slew};
            REG_MODE:  prdata = {30'b0, r_cfg.mode};
        endcase
    end

    assign s_axis_tready = core_idle;
    assign res_ready     = !r_m_valid || m_axis_tready;

    pvc_core u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_setpoint(s_axis_tdata[15:0]),
        .i_process_value(s_axis_tdata[31:16]),
        .i_now_seconds(s_axis_tdata[63:32]),
        .i_now_ticks(s_axis_tdata[77:64]),
        .o_idle(core_idle),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res(core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_res.elapsed_hundredths, r_m_res.control_value};
    assign m_axis_tuser  = r_m_res.solved;

endmodule

`default_nettype wire

FILE: hw/rtl/pvc_checker.sv
// ----------------------------------------------------------------------------
// PID velocity controller port checker
// Checks handshake and sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_velocity_controller_macros.svh"

module pvc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    logic        w_in_acc;
    logic        w_out_stall;
    logic [32:0] w_out_word;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_out_word  = {m_axis_tuser, m_axis_tdata};

    `PVC_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)
    `PVC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    `PVC_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, w_in_acc, !$rose(m_axis_tvalid))
    `PVC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && $stable(w_out_word))

endmodule

bind pid_velocity_controller pvc_checker u_pvc_checker (.*);

`default_nettype wire
